// ===== design/rwc_pkg.sv =====
`default_nettype none
package rwc_pkg;

   localparam int DEF_MAX_ASSETS  = 8;
   localparam int DEF_MAX_WINDOW  = 64;
   localparam int DEF_RETURN_BITS = 24;

   localparam int IDX_BITS      = 3;
   localparam int COV_BITS      = 50;
   localparam int MEAN_BITS     = 24;
   localparam int WIN_BITS      = 7;
   localparam int ASSETS_BITS   = 4;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 7;

   localparam logic [WIN_BITS-1:0]    WIN_RESET    = 7'd20;
   localparam logic [ASSETS_BITS-1:0] ASSETS_RESET = 4'd8;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WINDOW_LEN = 1'b0,
      CSR_ASSETS     = 1'b1
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MSUM,
      ST_MDRAIN,
      ST_MDIV,
      ST_MWAIT,
      ST_CLOAD,
      ST_CSUM,
      ST_CDRAIN,
      ST_CDIV,
      ST_CWAIT,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// ===== design/rwc_hist_mem.sv =====
`default_nettype none
module rwc_hist_mem #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int DW    = 24
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr_a,
   input  wire logic [AW-1:0] raddr_b,
   output logic      [DW-1:0] rdata_a,
   output logic      [DW-1:0] rdata_b
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule
`default_nettype wire

// ===== design/rwc_div.sv =====
`default_nettype none
module rwc_div #(
   parameter int DW = 56,
   parameter int VW = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [DW-1:0] dividend,
   input  wire logic        [VW-1:0] divisor,
   output logic                      done,
   output logic signed [DW-1:0]      quotient
);

   // radix-16: four restoring steps per cycle, quotient truncated toward zero
   localparam int PW    = ((DW + 3) / 4) * 4;
   localparam int ITER  = PW / 4;
   localparam int CW    = (ITER > 1) ? $clog2(ITER) : 1;

   logic [PW-1:0] mag_ff, mag_in;
   logic [VW:0]   rem_ff, rem_in;
   logic [VW-1:0] den_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW-1:0] q_ff;
   logic [DW-1:0] abs_val;
   logic [DW-1:0] mq;

   assign abs_val = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
   assign mq      = mag_in[DW-1:0];

   always_comb begin
      mag_in = mag_ff;
      rem_in = rem_ff;
      for (int i = 0; i < 4; i++) begin
         rem_in = {rem_in[VW-1:0], mag_in[PW-1]};
         mag_in = {mag_in[PW-2:0], 1'b0};
         if (rem_in >= {1'b0, den_ff}) begin
            rem_in    = rem_in - {1'b0, den_ff};
            mag_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(ITER - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= PW'(abs_val);
         rem_ff <= '0;
         den_ff <= divisor;
         neg_ff <= dividend[DW-1];
      end else if (busy_ff) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
         if (cnt_ff == CW'(ITER - 1)) begin
            q_ff <= neg_ff ? (~mq + 1'b1) : mq;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

// ===== design/rolling_window_covariance.sv =====
// channel | direction | handshake          | payload
// req     | in        | req_valid/ready    | return_value (Q3.20)
// rsp     | out       | rsp_valid/ready    | row, col, covariance, row_mean, last_of_run
// csr     | in        | csr_write_en       | csr_index, csr_wdata
//
// Items that do not close a period are taken in the idle state. A closing
// period runs the window sums over the history memory (two reads a cycle)
// and the 4-bit-per-cycle divider, first for each asset's mean, then for
// each of the n*n covariance entries.
// Reset is synchronous; the history memory and mean table are not cleared.
// req_ready is low while a matrix is computed; rsp stalls hold the sequencer.
`default_nettype none
module rolling_window_covariance #(
   parameter int MAX_ASSETS  = rwc_pkg::DEF_MAX_ASSETS,
   parameter int MAX_WINDOW  = rwc_pkg::DEF_MAX_WINDOW,
   parameter int RETURN_BITS = rwc_pkg::DEF_RETURN_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [RETURN_BITS-1:0]       req_return_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [rwc_pkg::IDX_BITS-1:0]             rsp_row_asset,
   output logic [rwc_pkg::IDX_BITS-1:0]             rsp_col_asset,
   output logic signed [rwc_pkg::COV_BITS-1:0]      rsp_covariance,
   output logic signed [rwc_pkg::MEAN_BITS-1:0]     rsp_row_mean,
   output logic                                     rsp_last_of_run,
   input  wire logic                                csr_write_en,
   input  wire logic [rwc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [rwc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rwc_pkg::*;

   localparam int AW    = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
   localparam int SW    = $clog2(MAX_WINDOW);
   localparam int DV_W  = $clog2(MAX_WINDOW + 1);
   localparam int NW    = $clog2(MAX_ASSETS + 1);
   localparam int DEPTH = MAX_ASSETS * MAX_WINDOW;
   localparam int HAW   = $clog2(DEPTH);
   localparam int DEV_W = RETURN_BITS + 1;
   localparam int PRD_W = 2 * DEV_W;
   localparam int ACC_W = PRD_W + SW;
   localparam int CXW   = (ACC_W > COV_BITS) ? ACC_W : COV_BITS;
   localparam int MXW   = (RETURN_BITS > MEAN_BITS) ? RETURN_BITS : MEAN_BITS;

   localparam logic signed [CXW-1:0] COV_HI =
      {{(CXW - COV_BITS + 1){1'b0}}, {(COV_BITS - 1){1'b1}}};
   localparam logic signed [CXW-1:0] COV_LO = ~COV_HI;
   localparam logic signed [MXW-1:0] MEAN_HI =
      {{(MXW - MEAN_BITS + 1){1'b0}}, {(MEAN_BITS - 1){1'b1}}};
   localparam logic signed [MXW-1:0] MEAN_LO = ~MEAN_HI;

   state_type state_ff, state_in;

   logic [WIN_BITS-1:0]    win_ff;
   logic [ASSETS_BITS-1:0] nas_ff;
   logic [AW-1:0]          cnt_ff, cnt_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [DV_W-1:0]        fill_ff, fill_in;
   logic [AW-1:0]          a_ff, a_in, b_ff, b_in;
   logic [SW-1:0]          k_ff, k_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                   mv_ff, mv_in, cv_ff, cv_in, pv_ff;
   logic signed [PRD_W-1:0] prod_ff;
   logic signed [RETURN_BITS-1:0] mean_a_ff, mean_b_ff;
   logic [RETURN_BITS-1:0] mean_mem [MAX_ASSETS];

   logic                   rsp_valid_ff;
   logic [IDX_BITS-1:0]    rsp_row_ff, rsp_col_ff;
   logic signed [COV_BITS-1:0]  rsp_cov_ff;
   logic signed [MEAN_BITS-1:0] rsp_mean_ff;
   logic                   rsp_last_ff;

   logic [DV_W-1:0] w;
   logic [NW-1:0]   n;
   logic [31:0]     w_raw, n_raw;
   logic            req_fire, rsp_load, mean_rd, mean_we, div_start;
   logic [SW-1:0]   sb;
   logic [31:0]     sb_wide;
   logic [RETURN_BITS-1:0] rdata_a, rdata_b;
   logic [HAW-1:0]  waddr, raddr_a, raddr_b;
   logic signed [DEV_W-1:0] dev_a, dev_b;
   logic signed [ACC_W-1:0] div_q;
   logic [DV_W-1:0] div_den;
   logic            div_done;
   logic signed [CXW-1:0] cov_x;
   logic signed [MXW-1:0] mean_x;
   logic            last_a, last_b;

   // effective window and asset count
   always_comb begin
      w_raw = 32'(win_ff);
      n_raw = 32'(nas_ff);
      if (w_raw < 32'd2) begin
         w = DV_W'(2);
      end else if (w_raw > 32'(MAX_WINDOW)) begin
         w = DV_W'(MAX_WINDOW);
      end else begin
         w = DV_W'(w_raw);
      end
      if (n_raw < 32'd1) begin
         n = NW'(1);
      end else if (n_raw > 32'(MAX_ASSETS)) begin
         n = NW'(MAX_ASSETS);
      end else begin
         n = NW'(n_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_RESET;
         nas_ff <= ASSETS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_reg_type'(csr_index))
            CSR_WINDOW_LEN: win_ff <= csr_wdata;
            CSR_ASSETS:     nas_ff <= csr_wdata[ASSETS_BITS-1:0];
            default:        win_ff <= win_ff;
         endcase
      end
   end

   // ring slot k periods back from the current one
   always_comb begin
      if (slot_ff >= k_ff) begin
         sb_wide = 32'(slot_ff) - 32'(k_ff);
      end else begin
         sb_wide = 32'(slot_ff) + 32'(MAX_WINDOW) - 32'(k_ff);
      end
      sb = sb_wide[SW-1:0];
   end

   assign req_fire = req_valid && req_ready;
   assign waddr    = HAW'(32'(cnt_ff) * 32'(MAX_WINDOW) + 32'(slot_ff));
   assign raddr_a  = HAW'(32'(a_ff) * 32'(MAX_WINDOW) + 32'(sb));
   assign raddr_b  = HAW'(32'(b_ff) * 32'(MAX_WINDOW) + 32'(sb));

   rwc_hist_mem #(
      .DEPTH (DEPTH),
      .AW    (HAW),
      .DW    (RETURN_BITS)
   ) u_hist (
      .clock   (clock),
      .we      (req_fire),
      .waddr   (waddr),
      .wdata   (req_return_value),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   assign div_den = (state_ff == ST_CDIV) ? (w - 1'b1) : w;

   rwc_div #(
      .DW (ACC_W),
      .VW (DV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign dev_a = DEV_W'(signed'(rdata_a)) - DEV_W'(mean_a_ff);
   assign dev_b = DEV_W'(signed'(rdata_b)) - DEV_W'(mean_b_ff);
   assign last_a = (NW'(a_ff) == n - 1'b1);
   assign last_b = (NW'(b_ff) == n - 1'b1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      k_in      = k_ff;
      mv_in     = 1'b0;
      cv_in     = 1'b0;
      mean_rd   = 1'b0;
      mean_we   = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      req_ready = 1'b0;
      acc_in    = acc_ff;
      if (mv_ff) begin
         acc_in = acc_ff + ACC_W'(signed'(rdata_a));
      end else if (pv_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (32'(cnt_ff) + 32'd1 < 32'(n)) begin
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  cnt_in = '0;
                  if (fill_ff != DV_W'(MAX_WINDOW)) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  if (fill_in >= w) begin
                     state_in = ST_MSUM;
                     a_in     = '0;
                     k_in     = '0;
                     acc_in   = '0;
                  end else begin
                     slot_in = (slot_ff == SW'(MAX_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
                  end
               end
            end
         end
         ST_MSUM: begin
            mv_in = 1'b1;
            k_in  = k_ff + 1'b1;
            if (DV_W'(k_ff) == w - 1'b1) begin
               state_in = ST_MDRAIN;
            end
         end
         ST_MDRAIN: begin
            if (!mv_ff) begin
               state_in = ST_MDIV;
            end
         end
         ST_MDIV: begin
            div_start = 1'b1;
            state_in  = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (div_done) begin
               mean_we = 1'b1;
               if (last_a) begin
                  state_in = ST_CLOAD;
                  a_in     = '0;
                  b_in     = '0;
               end else begin
                  state_in = ST_MSUM;
                  a_in     = a_ff + 1'b1;
                  k_in     = '0;
                  acc_in   = '0;
               end
            end
         end
         ST_CLOAD: begin
            mean_rd  = 1'b1;
            k_in     = '0;
            acc_in   = '0;
            state_in = ST_CSUM;
         end
         ST_CSUM: begin
            cv_in = 1'b1;
            k_in  = k_ff + 1'b1;
            if (DV_W'(k_ff) == w - 1'b1) begin
               state_in = ST_CDRAIN;
            end
         end
         ST_CDRAIN: begin
            if (!cv_ff && !pv_ff) begin
               state_in = ST_CDIV;
            end
         end
         ST_CDIV: begin
            div_start = 1'b1;
            state_in  = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_CLOAD;
               if (!last_b) begin
                  b_in = b_ff + 1'b1;
               end else if (!last_a) begin
                  a_in = a_ff + 1'b1;
                  b_in = '0;
               end else begin
                  state_in = ST_IDLE;
                  slot_in  = (slot_ff == SW'(MAX_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         slot_ff  <= '0;
         fill_ff  <= '0;
         mv_ff    <= 1'b0;
         cv_ff    <= 1'b0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
         mv_ff    <= mv_in;
         cv_ff    <= cv_in;
         pv_ff    <= cv_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      prod_ff <= dev_a * dev_b;
      if (mean_we) begin
         mean_mem[a_ff] <= div_q[RETURN_BITS-1:0];
      end
      if (mean_rd) begin
         mean_a_ff <= mean_mem[a_ff];
         mean_b_ff <= mean_mem[b_ff];
      end
   end

   // saturate to the output formats
   always_comb begin
      cov_x  = CXW'(div_q);
      mean_x = MXW'(mean_a_ff);
      if (cov_x > COV_HI) begin
         cov_x = COV_HI;
      end else if (cov_x < COV_LO) begin
         cov_x = COV_LO;
      end
      if (mean_x > MEAN_HI) begin
         mean_x = MEAN_HI;
      end else if (mean_x < MEAN_LO) begin
         mean_x = MEAN_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff  <= IDX_BITS'(a_ff);
         rsp_col_ff  <= IDX_BITS'(b_ff);
         rsp_cov_ff  <= cov_x[COV_BITS-1:0];
         rsp_mean_ff <= mean_x[MEAN_BITS-1:0];
         rsp_last_ff <= last_a && last_b;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_asset   = rsp_row_ff;
   assign rsp_col_asset   = rsp_col_ff;
   assign rsp_covariance  = rsp_cov_ff;
   assign rsp_row_mean    = rsp_mean_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_div_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CDIV) |-> (!cv_ff && !pv_ff && !mv_ff))
      else $error("divide started with products in flight");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_row_ff == rsp_col_ff))
      else $error("last entry off the diagonal");

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input taken during matrix pass");

endmodule
`default_nettype wire
